// ===== sv/tcbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbe_pkg
// shared sizes, codes and helpers of the text console buffer engine
// ----------------------------------------------------------------------------
package tcbe_pkg;

	localparam int NUM_ROWS   = 20;
	localparam int NUM_COLS   = 53;
	localparam int STATUS_ROW = NUM_ROWS - 1;
	localparam int CELLS      = NUM_ROWS * NUM_COLS;
	localparam int LOG_CELLS  = STATUS_ROW * NUM_COLS;
	localparam int COPY_CELLS = (STATUS_ROW - 1) * NUM_COLS;

	localparam int ROW_W  = $clog2(NUM_ROWS);
	localparam int COL_W  = $clog2(NUM_COLS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int OP_W   = 3;
	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;

	localparam int TAB_STOP = 4;
	localparam int TAB_W    = $clog2(TAB_STOP);
	localparam int CNT_W    = $clog2(TAB_STOP + 1);

	localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LOW   = 8'd32;
	localparam logic [BYTE_W-1:0] CH_HIGH  = 8'd126;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
	localparam logic [CHAR_W-1:0] CH_SUBST = 7'd63;

	typedef logic [NUM_ROWS-1:0] row_mask_t;
	typedef logic [ADDR_W-1:0]   addr_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUT_CHAR     = 3'd0,
		OP_CLEAR        = 3'd1,
		OP_MARK_INVERSE = 3'd2,
		OP_START_ROW    = 3'd3,
		OP_WRITE_CELL   = 3'd4,
		OP_READ_CELL    = 3'd5,
		OP_TAKE_FLAGS   = 3'd6,
		OP_FORCE_REDRAW = 3'd7
	} op_t;

	function automatic logic [CHAR_W-1:0] sanitize(input logic [BYTE_W-1:0] ch);
		if (ch < CH_LOW || ch > CH_HIGH) begin
			return CH_SUBST;
		end
		return ch[CHAR_W-1:0];
	endfunction

	function automatic addr_t cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(int'(r) * NUM_COLS + int'(c));
	endfunction

	function automatic row_mask_t row_bit(input logic [ROW_W-1:0] r);
		return row_mask_t'(1) << r;
	endfunction

endpackage

// ===== sv/text_console_buffer_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_buffer_engine
// character-cell console store with cursor, scroll and repaint flags
// ----------------------------------------------------------------------------
// The cell grid lives in one synchronous memory (one write and one read port,
// registered read data) driven by a small sequencer; one item is worked at
// a time and its result goes to an output register, so the next item is taken
// while a result waits. After reset the block sweeps every cell to space, one
// cell per cycle, before it takes an item. A tab stores one space per step up
// to the next tab stop; start_row sweeps its row to space and clear sweeps
// every cell. A new line on the last log row copies the log rows up one cell
// per cycle through the memory port pair and blanks the last log row.
// ----------------------------------------------------------------------------
module text_console_buffer_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [tcbe_pkg::OP_W-1:0]         opcode,
	input  logic [tcbe_pkg::BYTE_W-1:0]       char_code,
	input  logic [tcbe_pkg::ROW_W-1:0]        row_index,
	input  logic [tcbe_pkg::COL_W-1:0]        col_index,
	input  logic                              inverse_flag,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [tcbe_pkg::CHAR_W-1:0]       cell_char,
	output logic [tcbe_pkg::NUM_ROWS-1:0]     dirty_rows,
	output logic [tcbe_pkg::NUM_ROWS-1:0]     inverse_rows,
	output logic                              any_dirty,
	output logic                              full_redraw,
	output logic [tcbe_pkg::ROW_W-1:0]        cursor_row,
	output logic [tcbe_pkg::COL_W-1:0]        cursor_col
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_STORE,
		S_SWEEP,
		S_SCROLL,
		S_SDRAIN,
		S_DONE
	} state_t;

	state_t                          state_q;
	tcbe_pkg::op_t                   op_q;
	logic [tcbe_pkg::BYTE_W-1:0]     ch_q;
	logic [tcbe_pkg::ROW_W-1:0]      row_q;
	logic [tcbe_pkg::COL_W-1:0]      col_q;
	logic                            inv_q;

	logic [tcbe_pkg::ROW_W-1:0]      cur_row_q;
	logic [tcbe_pkg::COL_W-1:0]      cur_col_q;
	tcbe_pkg::row_mask_t             dirty_mask_q;
	tcbe_pkg::row_mask_t             inv_mask_q;
	logic                            dirty_bit_q;
	logic                            redraw_bit_q;

	tcbe_pkg::addr_t                 addr_q;
	tcbe_pkg::addr_t                 end_q;
	logic [tcbe_pkg::CNT_W-1:0]      cnt_q;
	logic [tcbe_pkg::CHAR_W-1:0]     chr_q;
	logic                            from_op_q;
	logic                            ovalid_q;

	logic                            wr_v_s1;
	tcbe_pkg::addr_t                 wr_addr_s1;

	logic [tcbe_pkg::CHAR_W-1:0]     mem [tcbe_pkg::CELLS];
	logic [tcbe_pkg::CHAR_W-1:0]     rdata_q;
	logic                            we;
	tcbe_pkg::addr_t                 waddr;
	tcbe_pkg::addr_t                 raddr;
	logic [tcbe_pkg::CHAR_W-1:0]     wdata;

	tcbe_pkg::addr_t                 cur_addr;
	tcbe_pkg::addr_t                 item_addr;
	tcbe_pkg::addr_t                 row_base;
	logic                            row_ok;
	logic                            col_ok;
	logic                            at_last_log;
	logic                            at_last_col;
	logic                            out_free;

	assign cur_addr    = tcbe_pkg::cell_addr(cur_row_q, cur_col_q);
	assign item_addr   = tcbe_pkg::cell_addr(row_q, col_q);
	assign row_base    = tcbe_pkg::cell_addr(row_q, '0);
	assign row_ok      = int'(row_q) < tcbe_pkg::NUM_ROWS;
	assign col_ok      = int'(col_q) < tcbe_pkg::NUM_COLS;
	assign at_last_log = int'(cur_row_q) >= tcbe_pkg::STATUS_ROW - 1;
	assign at_last_col = int'(cur_col_q) == tcbe_pkg::NUM_COLS - 1;
	assign out_free    = !ovalid_q || !result_stall;
	assign item_stall  = state_q != S_IDLE;
	assign result_valid = ovalid_q;

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = tcbe_pkg::CH_SPACE;
		priority if (wr_v_s1) begin
			we    = 1'b1;
			waddr = wr_addr_s1;
			wdata = (int'(wr_addr_s1) < tcbe_pkg::COPY_CELLS) ? rdata_q
				: tcbe_pkg::CH_SPACE;
		end else if (state_q == S_STORE) begin
			we    = 1'b1;
			waddr = cur_addr;
			wdata = chr_q;
		end else if (state_q == S_SWEEP) begin
			we    = 1'b1;
			waddr = addr_q;
		end else if (state_q == S_EXEC && op_q == tcbe_pkg::OP_WRITE_CELL
			&& row_ok && col_ok) begin
			we    = 1'b1;
			waddr = item_addr;
			wdata = tcbe_pkg::sanitize(ch_q);
		end else begin
			we    = 1'b0;
		end
	end

	assign raddr = (state_q == S_SCROLL)
		? tcbe_pkg::addr_t'(addr_q + tcbe_pkg::addr_t'(tcbe_pkg::NUM_COLS))
		: item_addr;

	// cell memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// scroll copy write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= state_q == S_SCROLL;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= addr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			op_q         <= tcbe_pkg::OP_PUT_CHAR;
			ch_q         <= '0;
			row_q        <= '0;
			col_q        <= '0;
			inv_q        <= 1'b0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			dirty_mask_q <= '1;
			inv_mask_q   <= '0;
			dirty_bit_q  <= 1'b1;
			redraw_bit_q <= 1'b1;
			addr_q       <= '0;
			end_q        <= tcbe_pkg::addr_t'(tcbe_pkg::CELLS - 1);
			cnt_q        <= '0;
			chr_q        <= tcbe_pkg::CH_SPACE;
			from_op_q    <= 1'b0;
			ovalid_q     <= 1'b0;
			cell_char    <= tcbe_pkg::CH_SPACE;
			dirty_rows   <= '0;
			inverse_rows <= '0;
			any_dirty    <= 1'b0;
			full_redraw  <= 1'b0;
			cursor_row   <= '0;
			cursor_col   <= '0;
		end else begin
			if (ovalid_q && !result_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q    <= tcbe_pkg::op_t'(opcode);
						ch_q    <= char_code;
						row_q   <= row_index;
						col_q   <= col_index;
						inv_q   <= inverse_flag;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						tcbe_pkg::OP_PUT_CHAR: begin
							priority if (ch_q == tcbe_pkg::CH_CR) begin
								state_q <= S_DONE;
							end else if (ch_q == tcbe_pkg::CH_LF) begin
								cur_col_q <= '0;
								cnt_q     <= '0;
								if (at_last_log) begin
									inv_mask_q   <= inv_mask_q >> 1;
									dirty_mask_q <= '1;
									dirty_bit_q  <= 1'b1;
									redraw_bit_q <= 1'b1;
									addr_q       <= '0;
									state_q      <= S_SCROLL;
								end else begin
									cur_row_q <= tcbe_pkg::ROW_W'(cur_row_q + 1'b1);
									state_q   <= S_DONE;
								end
							end else if (ch_q == tcbe_pkg::CH_TAB) begin
								chr_q   <= tcbe_pkg::CH_SPACE;
								cnt_q   <= tcbe_pkg::CNT_W'(tcbe_pkg::TAB_STOP)
									- tcbe_pkg::CNT_W'(cur_col_q[tcbe_pkg::TAB_W-1:0]);
								state_q <= S_STORE;
							end else begin
								chr_q   <= tcbe_pkg::sanitize(ch_q);
								cnt_q   <= tcbe_pkg::CNT_W'(1);
								state_q <= S_STORE;
							end
						end
						tcbe_pkg::OP_CLEAR: begin
							cur_row_q    <= '0;
							cur_col_q    <= '0;
							dirty_mask_q <= '1;
							inv_mask_q   <= '0;
							dirty_bit_q  <= 1'b1;
							redraw_bit_q <= 1'b1;
							addr_q       <= '0;
							end_q        <= tcbe_pkg::addr_t'(tcbe_pkg::CELLS - 1);
							from_op_q    <= 1'b1;
							state_q      <= S_SWEEP;
						end
						tcbe_pkg::OP_MARK_INVERSE: begin
							inv_mask_q <= inv_mask_q | tcbe_pkg::row_bit(cur_row_q);
							state_q    <= S_DONE;
						end
						tcbe_pkg::OP_START_ROW: begin
							if (row_ok) begin
								if (inv_q) begin
									inv_mask_q <= inv_mask_q | tcbe_pkg::row_bit(row_q);
								end else begin
									inv_mask_q <= inv_mask_q & ~tcbe_pkg::row_bit(row_q);
								end
								dirty_mask_q <= dirty_mask_q | tcbe_pkg::row_bit(row_q);
								dirty_bit_q  <= 1'b1;
								addr_q       <= row_base;
								end_q        <= tcbe_pkg::addr_t'(row_base
									+ tcbe_pkg::addr_t'(tcbe_pkg::NUM_COLS - 1));
								from_op_q    <= 1'b1;
								state_q      <= S_SWEEP;
							end else begin
								state_q <= S_DONE;
							end
						end
						tcbe_pkg::OP_WRITE_CELL: begin
							if (row_ok && col_ok) begin
								dirty_mask_q <= dirty_mask_q | tcbe_pkg::row_bit(row_q);
								dirty_bit_q  <= 1'b1;
							end
							state_q <= S_DONE;
						end
						tcbe_pkg::OP_READ_CELL: begin
							state_q <= S_DONE;
						end
						tcbe_pkg::OP_TAKE_FLAGS: begin
							state_q <= S_DONE;
						end
						tcbe_pkg::OP_FORCE_REDRAW: begin
							dirty_bit_q  <= 1'b1;
							redraw_bit_q <= 1'b1;
							state_q      <= S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_STORE: begin
					dirty_mask_q <= dirty_mask_q | tcbe_pkg::row_bit(cur_row_q);
					dirty_bit_q  <= 1'b1;
					cnt_q        <= tcbe_pkg::CNT_W'(cnt_q - 1'b1);
					if (at_last_col) begin
						cur_col_q <= '0;
						if (at_last_log) begin
							inv_mask_q   <= inv_mask_q >> 1;
							dirty_mask_q <= '1;
							redraw_bit_q <= 1'b1;
							addr_q       <= '0;
							state_q      <= S_SCROLL;
						end else begin
							cur_row_q <= tcbe_pkg::ROW_W'(cur_row_q + 1'b1);
							state_q   <= (cnt_q == tcbe_pkg::CNT_W'(1)) ? S_DONE : S_STORE;
						end
					end else begin
						cur_col_q <= tcbe_pkg::COL_W'(cur_col_q + 1'b1);
						state_q   <= (cnt_q == tcbe_pkg::CNT_W'(1)) ? S_DONE : S_STORE;
					end
				end
				S_SCROLL: begin
					addr_q <= tcbe_pkg::addr_t'(addr_q + 1'b1);
					if (int'(addr_q) == tcbe_pkg::LOG_CELLS - 1) begin
						state_q <= S_SDRAIN;
					end
				end
				S_SDRAIN: begin
					state_q <= (cnt_q != '0) ? S_STORE : S_DONE;
				end
				S_SWEEP: begin
					addr_q <= tcbe_pkg::addr_t'(addr_q + 1'b1);
					if (addr_q == end_q) begin
						from_op_q <= 1'b0;
						state_q   <= from_op_q ? S_DONE : S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						ovalid_q     <= 1'b1;
						cell_char    <= (op_q == tcbe_pkg::OP_READ_CELL && row_ok && col_ok)
							? rdata_q : tcbe_pkg::CH_SPACE;
						dirty_rows   <= dirty_mask_q;
						inverse_rows <= inv_mask_q;
						any_dirty    <= dirty_bit_q;
						full_redraw  <= redraw_bit_q;
						cursor_row   <= cur_row_q;
						cursor_col   <= cur_col_q;
						if (op_q == tcbe_pkg::OP_TAKE_FLAGS) begin
							dirty_mask_q <= '0;
							dirty_bit_q  <= 1'b0;
							redraw_bit_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== dv/console_shadow_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_shadow_compare
// Watches both channels of the text console buffer engine. It keeps its own
// copy of the cell grid, the cursor, the row masks and the repaint flags. It
// works out the expected result of every accepted item and compares each
// result item, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module console_shadow_compare
	import tcbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [BYTE_W-1:0]   char_code,
	input  logic [ROW_W-1:0]    row_index,
	input  logic [COL_W-1:0]    col_index,
	input  logic                inverse_flag,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic [CHAR_W-1:0]   cell_char,
	input  logic [NUM_ROWS-1:0] dirty_rows,
	input  logic [NUM_ROWS-1:0] inverse_rows,
	input  logic                any_dirty,
	input  logic                full_redraw,
	input  logic [ROW_W-1:0]    cursor_row,
	input  logic [COL_W-1:0]    cursor_col,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		row_mask_t         dirty;
		row_mask_t         inv;
		logic              any;
		logic              redraw;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_view_t;

	logic [CHAR_W-1:0] grid [NUM_ROWS][NUM_COLS];
	logic [ROW_W-1:0]  cur_r;
	logic [COL_W-1:0]  cur_c;
	row_mask_t         dirty_mask;
	row_mask_t         inverse_mask;
	logic              dirty_flag;
	logic              redraw_flag;
	console_view_t     expected_views [$];
	console_view_t     oldest;
	console_view_t     fresh;

	function automatic logic [CHAR_W-1:0] shown_glyph(input logic [BYTE_W-1:0] b);
		return (b inside {[CH_LOW:CH_HIGH]}) ? b[CHAR_W-1:0] : CH_SUBST;
	endfunction

	task automatic blank_row(input int r);
		for (int c = 0; c < NUM_COLS; c++) begin
			grid[r][c] = CH_SPACE;
		end
	endtask

	task automatic power_on();
		for (int r = 0; r < NUM_ROWS; r++) begin
			blank_row(r);
		end
		cur_r = '0;
		cur_c = '0;
		dirty_mask = '1;
		inverse_mask = '0;
		dirty_flag = 1'b1;
		redraw_flag = 1'b1;
	endtask

	// cursor goes down a row or, on the last log row, log rows move up one; status row stays put
	task automatic line_feed();
		cur_c = '0;
		if (cur_r < STATUS_ROW - 1) begin
			cur_r = cur_r + 1'b1;
		end else begin
			for (int r = 0; r < STATUS_ROW - 1; r++) begin
				for (int c = 0; c < NUM_COLS; c++) begin
					grid[r][c] = grid[r + 1][c];
				end
			end
			blank_row(STATUS_ROW - 1);
			inverse_mask = inverse_mask >> 1;
			dirty_mask = '1;
			dirty_flag = 1'b1;
			redraw_flag = 1'b1;
		end
	endtask

	// row is marked dirty before a possible wrap
	task automatic store_glyph(input logic [CHAR_W-1:0] g);
		grid[cur_r][cur_c] = g;
		dirty_mask[cur_r] = 1'b1;
		dirty_flag = 1'b1;
		cur_c = cur_c + 1'b1;
		if (cur_c >= NUM_COLS) begin
			line_feed();
		end
	endtask

	task automatic feed_byte(input logic [BYTE_W-1:0] b);
		int spaces;
		if (b == CH_LF) begin
			line_feed();
		end else if (b == CH_TAB) begin
			spaces = TAB_STOP - (cur_c % TAB_STOP);
			for (int i = 0; i < spaces; i++) begin
				store_glyph(CH_SPACE);
			end
		end else if (b != CH_CR) begin
			store_glyph(shown_glyph(b));
		end
	endtask

	task automatic apply_console_op(input op_t op, input logic [BYTE_W-1:0] ch,
		input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col, input logic flag,
		output console_view_t view);
		logic [CHAR_W-1:0] seen;
		logic row_ok;
		logic col_ok;
		seen = CH_SPACE;
		row_ok = row < NUM_ROWS;
		col_ok = col < NUM_COLS;
		case (op)
			OP_PUT_CHAR: feed_byte(ch);
			OP_CLEAR: power_on();
			OP_MARK_INVERSE: inverse_mask[cur_r] = 1'b1;
			OP_START_ROW: begin
				if (row_ok) begin
					blank_row(row);
					inverse_mask[row] = flag;
					dirty_mask[row] = 1'b1;
					dirty_flag = 1'b1;
				end
			end
			OP_WRITE_CELL: begin
				if (row_ok && col_ok) begin
					grid[row][col] = shown_glyph(ch);
					dirty_mask[row] = 1'b1;
					dirty_flag = 1'b1;
				end
			end
			OP_READ_CELL: begin
				if (row_ok && col_ok) begin
					seen = grid[row][col];
				end
			end
			OP_FORCE_REDRAW: begin
				dirty_flag = 1'b1;
				redraw_flag = 1'b1;
			end
			default: ;
		endcase
		view.glyph = seen;
		view.dirty = dirty_mask;
		view.inv = inverse_mask;
		view.any = dirty_flag;
		view.redraw = redraw_flag;
		view.row = cur_r;
		view.col = cur_c;
		// flags are reported before they are cleared
		if (op == OP_TAKE_FLAGS) begin
			dirty_mask = '0;
			dirty_flag = 1'b0;
			redraw_flag = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want !== got) begin
			$display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on();
			expected_views.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_views.size() == 0) begin
					$display("%0d ns: result item with nothing expected, actual char 0x%0h dirty 0x%0h inverse 0x%0h cursor %0d,%0d",
						$time, cell_char, dirty_rows, inverse_rows, cursor_row, cursor_col);
					fail_count++;
				end else begin
					oldest = expected_views.pop_front();
					check_field("cell_char", oldest.glyph, cell_char);
					check_field("dirty_rows", oldest.dirty, dirty_rows);
					check_field("inverse_rows", oldest.inv, inverse_rows);
					check_field("any_dirty", oldest.any, any_dirty);
					check_field("full_redraw", oldest.redraw, full_redraw);
					check_field("cursor_row", oldest.row, cursor_row);
					check_field("cursor_col", oldest.col, cursor_col);
				end
			end
			if (item_valid && !item_stall) begin
				apply_console_op(op_t'(opcode), char_code, row_index, col_index,
					inverse_flag, fresh);
				expected_views.push_back(fresh);
			end
			pending = expected_views.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the text console buffer engine with a short directed run over
// control bytes, edge characters and out-of-range rows and columns, then with
// random bursts of text, tab runs that wrap lines and scroll the log, and
// direct cell operations. Both channels idle at random. The shadow compare
// module checks every result item; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import tcbe_pkg::*;

	localparam int RANDOM_ITEMS    = 580;
	localparam int WATCHDOG_CYCLES = 8000;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic [OP_W-1:0]     opcode;
	logic [BYTE_W-1:0]   char_code;
	logic [ROW_W-1:0]    row_index;
	logic [COL_W-1:0]    col_index;
	logic                inverse_flag;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [CHAR_W-1:0]   cell_char;
	logic [NUM_ROWS-1:0] dirty_rows;
	logic [NUM_ROWS-1:0] inverse_rows;
	logic                any_dirty;
	logic                full_redraw;
	logic [ROW_W-1:0]    cursor_row;
	logic [COL_W-1:0]    cursor_col;
	int                  fail_count;
	int                  pending;
	logic                quiet_phase;
	int                  stall_run = 0;
	int                  idle_cycles = 0;
	int                  counted_items;
	logic [ROW_W-1:0]    last_row;
	logic [COL_W-1:0]    last_col;

	text_console_buffer_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.char_code(char_code),
		.row_index(row_index),
		.col_index(col_index),
		.inverse_flag(inverse_flag),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cell_char(cell_char),
		.dirty_rows(dirty_rows),
		.inverse_rows(inverse_rows),
		.any_dirty(any_dirty),
		.full_redraw(full_redraw),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col)
	);

	console_shadow_compare u_shadow (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.char_code(char_code),
		.row_index(row_index),
		.col_index(col_index),
		.inverse_flag(inverse_flag),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cell_char(cell_char),
		.dirty_rows(dirty_rows),
		.inverse_rows(inverse_rows),
		.any_dirty(any_dirty),
		.full_redraw(full_redraw),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [ROW_W-1:0] pick_row();
		if ($urandom_range(0, 99) < 85) begin
			return ROW_W'($urandom_range(0, NUM_ROWS - 1));
		end
		return ROW_W'($urandom_range(NUM_ROWS, (1 << ROW_W) - 1));
	endfunction

	function automatic logic [COL_W-1:0] pick_col();
		if ($urandom_range(0, 99) < 85) begin
			return COL_W'($urandom_range(0, NUM_COLS - 1));
		end
		return COL_W'($urandom_range(NUM_COLS, (1 << COL_W) - 1));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 68) begin
			return BYTE_W'($urandom_range(32, 126));
		end
		if (r < 78) begin
			return CH_LF;
		end
		if (r < 85) begin
			return CH_TAB;
		end
		if (r < 89) begin
			return CH_CR;
		end
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// receiver stall: runs of stall and no stall, no new stall run while quiet
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (result_stall || quiet_phase) begin
			result_stall <= 1'b0;
			stall_run <= $urandom_range(0, 10);
		end else begin
			result_stall <= 1'b1;
			stall_run <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("text_console_buffer_engine verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input op_t op, input logic [BYTE_W-1:0] ch,
		input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col, input logic flag);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		char_code <= ch;
		row_index <= row;
		col_index <= col;
		inverse_flag <= flag;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		// items the block ignores are not counted
		if (!((op == OP_START_ROW && row >= NUM_ROWS) ||
			(op == OP_WRITE_CELL && (row >= NUM_ROWS || col >= NUM_COLS)) ||
			(op == OP_PUT_CHAR && ch == CH_CR))) begin
			counted_items++;
		end
	endtask

	task automatic cell_op();
		int r;
		op_t op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			op = OP_WRITE_CELL;
		end else if (r < 60) begin
			op = OP_READ_CELL;
		end else if (r < 72) begin
			op = OP_TAKE_FLAGS;
		end else if (r < 82) begin
			op = OP_START_ROW;
		end else if (r < 92) begin
			op = OP_MARK_INVERSE;
		end else begin
			op = OP_FORCE_REDRAW;
		end
		row = pick_row();
		col = pick_col();
		if (op == OP_READ_CELL && $urandom_range(0, 1) == 1) begin
			row = last_row;
			col = last_col;
		end
		if (op == OP_WRITE_CELL) begin
			last_row = row;
			last_col = col;
		end
		send_item(op, BYTE_W'($urandom), row, col, 1'($urandom));
	endtask

	task automatic run_burst();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		quiet_phase <= ($urandom_range(0, 5) == 0);
		if (kind < 55) begin
			n = $urandom_range(4, 20);
			repeat (n) send_item(OP_PUT_CHAR, pick_text_byte(), ROW_W'($urandom),
				COL_W'($urandom), 1'($urandom));
		end else if (kind < 66) begin
			// tab runs fill a line and wrap, often in the middle of a tab
			n = $urandom_range(10, 18);
			repeat (n) send_item(OP_PUT_CHAR, ($urandom_range(0, 3) == 0) ?
				BYTE_W'($urandom_range(32, 126)) : CH_TAB, ROW_W'($urandom),
				COL_W'($urandom), 1'($urandom));
		end else if (kind < 97) begin
			n = $urandom_range(3, 12);
			repeat (n) cell_op();
		end else begin
			send_item(OP_CLEAR, BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom),
				1'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = '0;
		char_code = '0;
		row_index = '0;
		col_index = '0;
		inverse_flag = 1'b0;
		quiet_phase = 1'b0;
		counted_items = 0;
		last_row = '0;
		last_col = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: flags after reset, control and edge bytes, bad indexes
		send_item(OP_TAKE_FLAGS, 8'd0, 5'd0, 6'd0, 1'b0);
		send_item(OP_TAKE_FLAGS, 8'd255, 5'd31, 6'd63, 1'b1);
		send_item(OP_PUT_CHAR, 8'd65, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, CH_CR, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, 8'd0, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, 8'd255, 5'd31, 6'd63, 1'b1);
		send_item(OP_PUT_CHAR, CH_HIGH, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, 8'd127, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, CH_LOW, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, 8'd31, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, CH_TAB, 5'd0, 6'd0, 1'b0);
		send_item(OP_PUT_CHAR, CH_LF, 5'd0, 6'd0, 1'b0);
		send_item(OP_MARK_INVERSE, 8'd0, 5'd0, 6'd0, 1'b0);
		send_item(OP_START_ROW, 8'd0, 5'd19, 6'd0, 1'b1);
		send_item(OP_START_ROW, 8'd0, 5'd1, 6'd0, 1'b0);
		send_item(OP_START_ROW, 8'd0, 5'd25, 6'd0, 1'b1);
		send_item(OP_WRITE_CELL, CH_HIGH, 5'd19, 6'd52, 1'b0);
		send_item(OP_WRITE_CELL, 8'd200, 5'd0, 6'd0, 1'b0);
		send_item(OP_WRITE_CELL, 8'd66, 5'd20, 6'd5, 1'b0);
		send_item(OP_WRITE_CELL, 8'd67, 5'd3, 6'd53, 1'b0);
		send_item(OP_READ_CELL, 8'd0, 5'd19, 6'd52, 1'b0);
		send_item(OP_READ_CELL, 8'd0, 5'd0, 6'd0, 1'b0);
		send_item(OP_READ_CELL, 8'd0, 5'd31, 6'd63, 1'b0);
		send_item(OP_FORCE_REDRAW, 8'd0, 5'd0, 6'd0, 1'b0);
		send_item(OP_CLEAR, 8'd0, 5'd0, 6'd0, 1'b0);

		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			run_burst();
		end
		item_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("text_console_buffer_engine verification clean");
		end else begin
			$display("text_console_buffer_engine verification failed");
		end
		$finish;
	end

endmodule
